@@ design/cre_pkg.sv @@
package cre_pkg;

    localparam int CHAR_W           = 8;
    localparam int CAP_W            = 16;
    localparam int BYTES_PER_RESULT = 8;
    localparam int LANE_W           = $clog2(BYTES_PER_RESULT);
    localparam int FILL_W           = $clog2(BYTES_PER_RESULT + 1);
    localparam int OUT_W            = BYTES_PER_RESULT * CHAR_W;

    localparam logic [CAP_W-1:0]  CAP_RESET = 16'd1000;
    localparam logic [CHAR_W-1:0] HYPHEN    = 8'h2D;
    localparam logic [CHAR_W-1:0] NUL       = 8'h00;

    typedef logic [BYTES_PER_RESULT-1:0][CHAR_W-1:0] cre_lanes_t;

    // sequencer to packer
    typedef struct packed {
        logic              emit;
        logic [CHAR_W-1:0] data;
        logic              finish;
    } cre_pack_req_t;

    // packer to sequencer
    typedef struct packed {
        logic emit_take;
        logic finish_take;
        logic pack_full;
        logic cap_hit;
    } cre_pack_stat_t;

endpackage

@@ design/cre_packer.sv @@
module cre_packer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [cre_pkg::CAP_W-1:0]    cap,
    input  cre_pkg::cre_pack_req_t       req,
    output cre_pkg::cre_pack_stat_t      stat,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cre_pkg::OUT_W-1:0]    m_out_chars,
    output logic [cre_pkg::FILL_W-1:0]   m_out_count,
    output logic                         m_string_done
);
    import cre_pkg::*;

    cre_lanes_t        buf_reg, buf_next, base_buf;
    logic [FILL_W-1:0] fill_reg, fill_next, base_fill;
    logic [CAP_W-1:0]  written_reg, written_next;
    logic              valid_reg, valid_next;
    cre_lanes_t        chars_reg, chars_next;
    logic [FILL_W-1:0] count_reg, count_next;
    logic              done_reg, done_next;

    logic out_free, pack_full, send_full, finish_go, emit_go, cap_hit;

    always_comb begin
        out_free  = !valid_reg || m_ready;
        pack_full = (fill_reg == FILL_W'(BYTES_PER_RESULT));
        send_full = pack_full && out_free;
        finish_go = req.finish && !pack_full && out_free;
        emit_go   = req.emit && (!pack_full || out_free);
        cap_hit   = (written_reg >= cap);

        // a full pack leaves for the output register while the next byte lands in lane 0
        base_buf  = send_full ? '0 : buf_reg;
        base_fill = send_full ? '0 : fill_reg;

        buf_next     = base_buf;
        fill_next    = base_fill;
        written_next = written_reg;
        if (emit_go && !cap_hit) begin
            buf_next[base_fill[LANE_W-1:0]] = req.data;
            fill_next    = base_fill + FILL_W'(1);
            written_next = written_reg + CAP_W'(1);
        end
        if (finish_go) begin
            buf_next     = '0;
            fill_next    = '0;
            written_next = '0;
        end

        valid_next = valid_reg;
        chars_next = chars_reg;
        count_next = count_reg;
        done_next  = done_reg;
        if (send_full || finish_go) begin
            valid_next = 1'b1;
            chars_next = buf_reg;
            count_next = fill_reg;
            done_next  = finish_go;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            fill_reg    <= '0;
            written_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            buf_reg     <= buf_next;
            fill_reg    <= fill_next;
            written_reg <= written_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
        count_reg <= count_next;
        done_reg  <= done_next;
    end

    assign stat.emit_take   = emit_go;
    assign stat.finish_take = finish_go;
    assign stat.pack_full   = pack_full;
    assign stat.cap_hit     = cap_hit;

    assign m_valid       = valid_reg;
    assign m_out_chars   = chars_reg;
    assign m_out_count   = count_reg;
    assign m_string_done = done_reg;

endmodule

@@ design/char_range_expander_unit.sv @@
// Character range expander. Bytes of a string come in one request at a time on the s_ side;
// a zero byte ends the string. A pattern x-y becomes every byte from x to y inclusive,
// counting down when y is below x; in a chain like a-c-e the shared endpoint is sent once,
// and a hyphen at the start, at the end or with nothing after it stays literal. Output
// bytes are packed eight to a request on the m_ side, first byte in bits 7:0, unused lanes
// zero. Each string ends with one request that has m_string_done set, even when it carries
// no bytes. Once cfg_wdata's capacity (reset 1000) is reached, the rest of the string's
// output is dropped. A byte that only fills the look-ahead window or is copied literally
// is handled as it is accepted; a range sends each byte it covers (up to 255) in order, as
// the packer writes one lane per cycle while the output side does not stall it, and a range
// cut at the capacity stops on the first dropped byte; the end of a string flushes the window
// bytes and then sends the closing request. Whenever the output side holds back a full pack,
// emission stalls until it is taken.
module char_range_expander_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cre_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cre_pkg::CHAR_W-1:0]    s_char_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cre_pkg::OUT_W-1:0]     m_out_chars,
    output logic [cre_pkg::FILL_W-1:0]    m_out_count,
    output logic                          m_string_done
);
    import cre_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;  // take bytes, handle literals
    localparam logic [2:0] ST_RANGE     = 3'd1;  // walk a range one byte per cycle while the packer takes it
    localparam logic [2:0] ST_FLUSH_OLD = 3'd2;  // string end: older window byte
    localparam logic [2:0] ST_FLUSH_NEW = 3'd3;  // string end: newer window byte
    localparam logic [2:0] ST_FINAL     = 3'd4;  // send the closing request

    logic [2:0]        state_reg, state_next;
    logic [CHAR_W-1:0] older_reg, older_next;
    logic [CHAR_W-1:0] newer_reg, newer_next;
    logic [1:0]        fill_reg, fill_next;
    logic              pending_reg, pending_next;   // older byte already sent as a range end
    logic [CHAR_W-1:0] cur_reg, cur_next;           // range walker
    logic [CHAR_W-1:0] last_reg, last_next;
    logic              up_reg, up_next;
    logic [CAP_W-1:0]  cap_reg;

    cre_pack_req_t  pk_req;
    cre_pack_stat_t pk_stat;

    logic take;

    assign s_ready = (state_reg == ST_IDLE) && !pk_stat.pack_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        fill_next    = fill_reg;
        pending_next = pending_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        up_next      = up_reg;
        pk_req       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_char_in == NUL) begin
                        // window goes out as literals, a held endpoint is not repeated
                        if (fill_reg != 2'd0 && !pending_reg) begin
                            state_next = ST_FLUSH_OLD;
                        end else if (fill_reg == 2'd2) begin
                            state_next = ST_FLUSH_NEW;
                        end else begin
                            state_next = ST_FINAL;
                        end
                    end else if (fill_reg == 2'd0) begin
                        older_next = s_char_in;
                        fill_next  = 2'd1;
                    end else if (fill_reg == 2'd1) begin
                        newer_next = s_char_in;
                        fill_next  = 2'd2;
                    end else if (newer_reg == HYPHEN) begin
                        // range older..s_char_in; skip the start when it was already sent
                        up_next   = (s_char_in >= older_reg);
                        last_next = s_char_in;
                        if (!pending_reg) begin
                            cur_next   = older_reg;
                            state_next = ST_RANGE;
                        end else if (older_reg != s_char_in) begin
                            cur_next   = (s_char_in >= older_reg) ? older_reg + CHAR_W'(1)
                                                                  : older_reg - CHAR_W'(1);
                            state_next = ST_RANGE;
                        end
                        older_next   = s_char_in;
                        newer_next   = NUL;
                        fill_next    = 2'd1;
                        pending_next = 1'b1;
                    end else begin
                        // literal; the pack has room since s_ready excludes a full pack
                        pk_req.emit  = !pending_reg;
                        pk_req.data  = older_reg;
                        pending_next = 1'b0;
                        older_next   = newer_reg;
                        newer_next   = s_char_in;
                    end
                end
            end
            ST_RANGE: begin
                pk_req.emit = 1'b1;
                pk_req.data = cur_reg;
                if (pk_stat.emit_take) begin
                    // past capacity every later byte is dropped, so stop early
                    if (cur_reg == last_reg || pk_stat.cap_hit) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next = up_reg ? cur_reg + CHAR_W'(1) : cur_reg - CHAR_W'(1);
                    end
                end
            end
            ST_FLUSH_OLD: begin
                pk_req.emit = 1'b1;
                pk_req.data = older_reg;
                if (pk_stat.emit_take) begin
                    state_next = (fill_reg == 2'd2) ? ST_FLUSH_NEW : ST_FINAL;
                end
            end
            ST_FLUSH_NEW: begin
                pk_req.emit = 1'b1;
                pk_req.data = newer_reg;
                if (pk_stat.emit_take) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                pk_req.finish = 1'b1;
                if (pk_stat.finish_take) begin
                    older_next   = NUL;
                    newer_next   = NUL;
                    fill_next    = 2'd0;
                    pending_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            older_reg   <= NUL;
            newer_reg   <= NUL;
            fill_reg    <= 2'd0;
            pending_reg <= 1'b0;
            cap_reg     <= CAP_RESET;
        end else begin
            state_reg   <= state_next;
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        last_reg <= last_next;
        up_reg   <= up_next;
    end

    cre_packer u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cap           (cap_reg),
        .req           (pk_req),
        .stat          (pk_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_chars   (m_out_chars),
        .m_out_count   (m_out_count),
        .m_string_done (m_string_done)
    );

    // a held endpoint always sits in the window
    a_pending_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> fill_reg != 2'd0)
        else $error("endpoint flag set with empty window");

    // the range walker holds while the packer is stalled
    a_range_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RANGE && !pk_stat.emit_take) |=> $stable(cur_reg))
        else $error("range walker moved without a byte taken");

    // closing request leaves the window empty and the sequencer idle
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        pk_stat.finish_take |=> (state_reg == ST_IDLE && fill_reg == 2'd0 && !pending_reg))
        else $error("string end left state behind");

    // no new byte is taken while the sequencer is busy
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> (state_reg == ST_IDLE && !pk_req.finish))
        else $error("byte taken outside idle");

endmodule
